// ----- rtl/pwl_pkg.sv -----
`default_nettype none
package pwl_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int PROD_W = 2 * DATA_W;
    localparam int STEP_W = $clog2(PROD_W);
    localparam int QUO_W = 41;
    localparam int SUM_W = QUO_W + 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_AXIS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd1;

    localparam logic AXIS_X = 1'b0;

    typedef struct packed {
        logic                     op;
        logic [7:0]               entry_index;
        logic signed [DATA_W-1:0] entry_x;
        logic signed [DATA_W-1:0] entry_y;
        logic signed [DATA_W-1:0] query_value;
    } in_item_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] result_value;
    } out_item_t;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FIRST = 11'b000_0000_0010,
        S_LAST  = 11'b000_0000_0100,
        S_PROBE = 11'b000_0000_1000,
        S_CMP   = 11'b000_0001_0000,
        S_LOWER = 11'b000_0010_0000,
        S_UPPER = 11'b000_0100_0000,
        S_MUL   = 11'b000_1000_0000,
        S_DIV   = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/pwl_ram.sv -----
`default_nettype none
module pwl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/piecewise_linear_curve_lookup.sv -----
`default_nettype none
// Piecewise-linear curve lookup over a table of signed Q16.16 (x, y) points held in one
// single-port-read RAM. A write transfer (op = 0) stores one point. A query transfer
// (op = 1) goes straight to the hand-over when the table is empty and stops after the
// first-key or last-key check when the query lies outside the key range. Otherwise it
// checks the range against the first and last keys, runs a binary search with one RAM
// read per probe, closes the search and fetches the two neighbors, and for a true
// interpolation does a 32x32 multiply, a restoring divide, a saturation to the 32-bit
// range and the hand-over of the result. The block accepts no new transfer while a
// query is in progress; a finished result sits in the output register so the next
// transfer can be taken while it waits.
module piecewise_linear_curve_lookup (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire pwl_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output pwl_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_we,
    input  wire logic [pwl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pwl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pwl_pkg::state_t state_reg, state_next;

    logic                                axis_reg;
    logic [pwl_pkg::CFG_DATA_W-1:0]      count_reg;
    logic signed [pwl_pkg::DATA_W-1:0]   q_reg, q_next;
    logic [pwl_pkg::CNT_W-1:0]           lo_reg, lo_next;
    logic [pwl_pkg::CNT_W-1:0]           len_reg, len_next;
    logic signed [pwl_pkg::DATA_W-1:0]   vfirst_reg, vfirst_next;
    logic signed [pwl_pkg::DATA_W-1:0]   k1_reg, k1_next;
    logic signed [pwl_pkg::DATA_W-1:0]   v1_reg, v1_next;
    logic [pwl_pkg::DATA_W-1:0]          a_reg, a_next;
    logic [pwl_pkg::DATA_W-1:0]          b_reg, b_next;
    logic [pwl_pkg::DATA_W-1:0]          den_reg, den_next;
    logic                                neg_reg, neg_next;
    logic [pwl_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic [pwl_pkg::DATA_W-1:0]          rem_reg, rem_next;
    logic [pwl_pkg::PROD_W-1:0]          quo_reg, quo_next;
    logic [pwl_pkg::STEP_W-1:0]          step_reg, step_next;
    logic                                found_reg, found_next;
    logic signed [pwl_pkg::DATA_W-1:0]   res_reg, res_next;
    logic                                out_valid_reg;
    pwl_pkg::out_item_t                  out_data_reg;

    logic                                in_accept;
    logic                                out_free;
    logic [pwl_pkg::CNT_W-1:0]           n_eff;
    logic [pwl_pkg::CNT_W-1:0]           lo_c;
    logic [pwl_pkg::CNT_W-1:0]           mid;
    logic [pwl_pkg::ADDR_W-1:0]          rd_addr;
    logic [pwl_pkg::ENTRY_W-1:0]         rd_data;
    logic                                wr_en;
    logic signed [pwl_pkg::DATA_W-1:0]   rd_x, rd_y, rd_key, rd_val;
    logic signed [pwl_pkg::DATA_W:0]     d_num, d_mul, d_den;
    logic [pwl_pkg::DATA_W:0]            rem_sh;
    logic [pwl_pkg::QUO_W-1:0]           quo_clamp;
    logic signed [pwl_pkg::SUM_W-1:0]    sum;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != pwl_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign n_eff = (32'(count_reg) > 32'(pwl_pkg::TABLE_DEPTH))
                 ? pwl_pkg::CNT_W'(pwl_pkg::TABLE_DEPTH) : pwl_pkg::CNT_W'(count_reg);
    assign lo_c  = (lo_reg >= n_eff) ? n_eff - 1'b1 : lo_reg;
    assign mid   = lo_reg + (len_reg >> 1);

    assign wr_en = in_accept && (in_data.op == pwl_pkg::OP_WRITE)
                 && (32'(in_data.entry_index) < 32'(pwl_pkg::TABLE_DEPTH));

    assign rd_x   = rd_data[pwl_pkg::ENTRY_W-1:pwl_pkg::DATA_W];
    assign rd_y   = rd_data[pwl_pkg::DATA_W-1:0];
    assign rd_key = (axis_reg == pwl_pkg::AXIS_X) ? rd_x : rd_y;
    assign rd_val = (axis_reg == pwl_pkg::AXIS_X) ? rd_y : rd_x;

    pwl_ram #(
        .WIDTH (pwl_pkg::ENTRY_W),
        .DEPTH (pwl_pkg::TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (pwl_pkg::ADDR_W'(in_data.entry_index)),
        .wdata ({in_data.entry_x, in_data.entry_y}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Address presented in each state; the registered data is seen in the next state.
    always_comb
    begin
        unique case (state_reg)
            pwl_pkg::S_FIRST: rd_addr = pwl_pkg::ADDR_W'(n_eff - 1'b1);
            pwl_pkg::S_PROBE: rd_addr = (len_reg != '0) ? pwl_pkg::ADDR_W'(mid)
                                                        : pwl_pkg::ADDR_W'(lo_c - 1'b1);
            pwl_pkg::S_LOWER: rd_addr = pwl_pkg::ADDR_W'(lo_c);
            default:          rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwl_pkg::CFG_QUERY_AXIS:  axis_reg  <= cfg_data[0];
                pwl_pkg::CFG_POINT_COUNT: count_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        d_num     = 33'(q_reg) - 33'(k1_reg);
        d_mul     = 33'(rd_val) - 33'(v1_reg);
        d_den     = 33'(rd_key) - 33'(k1_reg);
        rem_sh    = {rem_reg, prod_reg[pwl_pkg::PROD_W-1]};
        quo_clamp = (quo_reg > pwl_pkg::PROD_W'(1) << (pwl_pkg::QUO_W - 1))
                  ? pwl_pkg::QUO_W'(1) << (pwl_pkg::QUO_W - 1) : quo_reg[pwl_pkg::QUO_W-1:0];
        sum       = neg_reg ? pwl_pkg::SUM_W'(v1_reg) - $signed({2'b00, quo_clamp})
                            : pwl_pkg::SUM_W'(v1_reg) + $signed({2'b00, quo_clamp});

        state_next  = state_reg;
        q_next      = q_reg;
        lo_next     = lo_reg;
        len_next    = len_reg;
        vfirst_next = vfirst_reg;
        k1_next     = k1_reg;
        v1_next     = v1_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        res_next    = res_reg;

        unique case (state_reg)
            pwl_pkg::S_IDLE:
            begin
                if (in_accept && in_data.op == pwl_pkg::OP_QUERY)
                begin
                    q_next     = in_data.query_value;
                    found_next = 1'b0;
                    res_next   = '0;
                    state_next = (n_eff == '0) ? pwl_pkg::S_DONE : pwl_pkg::S_FIRST;
                end
            end
            pwl_pkg::S_FIRST:
            begin
                vfirst_next = rd_val;
                state_next  = (q_reg < rd_key) ? pwl_pkg::S_DONE : pwl_pkg::S_LAST;
            end
            pwl_pkg::S_LAST:
            begin
                lo_next    = '0;
                len_next   = n_eff;
                state_next = (q_reg > rd_key) ? pwl_pkg::S_DONE : pwl_pkg::S_PROBE;
            end
            pwl_pkg::S_PROBE:
            begin
                if (len_reg != '0)
                begin
                    state_next = pwl_pkg::S_CMP;
                end
                else if (lo_c == '0)
                begin
                    found_next = 1'b1;
                    res_next   = vfirst_reg;
                    state_next = pwl_pkg::S_DONE;
                end
                else
                begin
                    state_next = pwl_pkg::S_LOWER;
                end
            end
            pwl_pkg::S_CMP:
            begin
                if (rd_key < q_reg)
                begin
                    lo_next  = mid + 1'b1;
                    len_next = len_reg - (len_reg >> 1) - 1'b1;
                end
                else
                begin
                    len_next = len_reg >> 1;
                end
                state_next = pwl_pkg::S_PROBE;
            end
            pwl_pkg::S_LOWER:
            begin
                k1_next    = rd_key;
                v1_next    = rd_val;
                state_next = pwl_pkg::S_UPPER;
            end
            pwl_pkg::S_UPPER:
            begin
                found_next = 1'b1;
                if (rd_key == k1_reg)
                begin
                    res_next   = v1_reg;
                    state_next = pwl_pkg::S_DONE;
                end
                else
                begin
                    // Differences of two 32-bit values have magnitudes below 2^32.
                    a_next     = pwl_pkg::DATA_W'(d_num[pwl_pkg::DATA_W] ? -d_num : d_num);
                    b_next     = pwl_pkg::DATA_W'(d_mul[pwl_pkg::DATA_W] ? -d_mul : d_mul);
                    den_next   = pwl_pkg::DATA_W'(d_den[pwl_pkg::DATA_W] ? -d_den : d_den);
                    neg_next   = (d_num[pwl_pkg::DATA_W] != d_mul[pwl_pkg::DATA_W])
                               != d_den[pwl_pkg::DATA_W];
                    state_next = pwl_pkg::S_MUL;
                end
            end
            pwl_pkg::S_MUL:
            begin
                prod_next  = a_reg * b_reg;
                rem_next   = '0;
                quo_next   = '0;
                step_next  = '0;
                state_next = pwl_pkg::S_DIV;
            end
            pwl_pkg::S_DIV:
            begin
                // One restoring step per cycle, dividend bits taken from the top.
                prod_next = prod_reg << 1;
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = pwl_pkg::DATA_W'(rem_sh - {1'b0, den_reg});
                    quo_next = {quo_reg[pwl_pkg::PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[pwl_pkg::DATA_W-1:0];
                    quo_next = {quo_reg[pwl_pkg::PROD_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == pwl_pkg::STEP_W'(pwl_pkg::PROD_W - 1))
                begin
                    state_next = pwl_pkg::S_FIN;
                end
            end
            pwl_pkg::S_FIN:
            begin
                if (sum > pwl_pkg::SUM_W'(32'sh7FFF_FFFF))
                begin
                    res_next = 32'sh7FFF_FFFF;
                end
                else if (sum < pwl_pkg::SUM_W'(32'sh8000_0000))
                begin
                    res_next = 32'sh8000_0000;
                end
                else
                begin
                    res_next = sum[pwl_pkg::DATA_W-1:0];
                end
                state_next = pwl_pkg::S_DONE;
            end
            pwl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pwl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pwl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pwl_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        vfirst_reg <= vfirst_next;
        k1_reg     <= k1_next;
        v1_reg     <= v1_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        found_reg  <= found_next;
        res_reg    <= res_next;
        if (state_reg == pwl_pkg::S_DONE && out_free)
        begin
            out_data_reg.found        <= found_reg;
            out_data_reg.result_value <= res_reg;
        end
    end

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.result_value == '0)
        else $error("not-found result carries a nonzero value");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_data.op == pwl_pkg::OP_QUERY |=> in_stall)
        else $error("query transfer did not start the search");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pwl_pkg::S_PROBE |-> 32'(lo_reg) + 32'(len_reg) <= 32'(n_eff))
        else $error("binary search window left the table");

endmodule
`default_nettype wire

// ----- verif/tb_piecewise_linear_curve_lookup.sv -----
module tb_piecewise_linear_curve_lookup;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int ITEM_TARGET = 1150;
    localparam int DRAIN_CYCLES = 150;

    class curve_scoreboard;
        logic signed [pwl_pkg::DATA_W-1:0] xs [pwl_pkg::TABLE_DEPTH];
        logic signed [pwl_pkg::DATA_W-1:0] ys [pwl_pkg::TABLE_DEPTH];
        logic axis;
        int unsigned count;
        pwl_pkg::out_item_t lookups_due[$];
        int mismatches;
        int queries;
        int hits;
        int writes;

        function new();
            for (int i = 0; i < pwl_pkg::TABLE_DEPTH; i++)
            begin
                xs[i] = '0;
                ys[i] = '0;
            end
            axis = pwl_pkg::AXIS_X;
            count = 0;
            mismatches = 0;
            queries = 0;
            hits = 0;
            writes = 0;
        endfunction

        function void set_register(logic [pwl_pkg::CFG_IDX_W-1:0] idx,
                                   logic [pwl_pkg::CFG_DATA_W-1:0] data);
            if (idx == pwl_pkg::CFG_QUERY_AXIS)
                axis = data[0];
            else if (idx == pwl_pkg::CFG_POINT_COUNT)
                count = data;
        endfunction

        function longint key_at(int i);
            return (axis == pwl_pkg::AXIS_X) ? longint'(xs[i]) : longint'(ys[i]);
        endfunction

        function longint val_at(int i);
            return (axis == pwl_pkg::AXIS_X) ? longint'(ys[i]) : longint'(xs[i]);
        endfunction

        // Exact product, quotient truncated toward zero and capped at 2^40,
        // then the sum is clamped to the signed 32-bit range.
        function longint blend(longint base, longint num, longint mul, longint den);
            logic [127:0] prod;
            logic [127:0] quo;
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] md;
            logic neg;
            longint r;
            ma = (num < 0) ? -num : num;
            mb = (mul < 0) ? -mul : mul;
            md = (den < 0) ? -den : den;
            neg = (num < 0) ^ (mul < 0) ^ (den < 0);
            prod = {64'd0, ma} * {64'd0, mb};
            quo = prod / {64'd0, md};
            if (quo > (128'd1 << 40))
                quo = 128'd1 << 40;
            r = neg ? base - longint'(quo[63:0]) : base + longint'(quo[63:0]);
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r;
        endfunction

        function void note_transfer(pwl_pkg::in_item_t it);
            pwl_pkg::out_item_t exp_item;
            int n;
            int lo;
            int len;
            int half;
            int mid;
            longint q;
            longint k1;
            longint k2;
            longint res;
            if (it.op == pwl_pkg::OP_WRITE)
            begin
                xs[it.entry_index] = it.entry_x;
                ys[it.entry_index] = it.entry_y;
                writes++;
                return;
            end
            queries++;
            n = (count > pwl_pkg::TABLE_DEPTH) ? pwl_pkg::TABLE_DEPTH : count;
            q = it.query_value;
            exp_item.found = 1'b0;
            exp_item.result_value = '0;
            if (n != 0 && q >= key_at(0) && q <= key_at(n - 1))
            begin
                lo = 0;
                len = n;
                while (len > 0)
                begin
                    half = len >> 1;
                    mid = lo + half;
                    if (key_at(mid) < q)
                    begin
                        lo = mid + 1;
                        len -= half + 1;
                    end
                    else
                        len = half;
                end
                if (lo >= n)
                    lo = n - 1;
                if (lo == 0)
                    res = val_at(0);
                else
                begin
                    k1 = key_at(lo - 1);
                    k2 = key_at(lo);
                    if (k1 == k2)
                        res = val_at(lo - 1);
                    else
                        res = blend(val_at(lo - 1), q - k1, val_at(lo) - val_at(lo - 1),
                                    k2 - k1);
                end
                exp_item.found = 1'b1;
                exp_item.result_value = res[pwl_pkg::DATA_W-1:0];
            end
            lookups_due.push_back(exp_item);
        endfunction

        function void check_result(pwl_pkg::out_item_t got);
            pwl_pkg::out_item_t exp_item;
            if (lookups_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: found=%0b value=%h",
                             got.found, got.result_value);
                return;
            end
            exp_item = lookups_due.pop_front();
            if (got.found)
                hits++;
            if (got.found !== exp_item.found || got.result_value !== exp_item.result_value)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected found=%0b value=%h, got found=%0b value=%h",
                             exp_item.found, exp_item.result_value,
                             got.found, got.result_value);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pwl_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    pwl_pkg::out_item_t out_data;
    logic cfg_we;
    logic [pwl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pwl_pkg::CFG_DATA_W-1:0] cfg_data;

    curve_scoreboard sb;
    int items_sent;
    int phases;
    int cycles;
    bit quiet;
    int hold_cycles;
    logic signed [pwl_pkg::DATA_W-1:0] keys [pwl_pkg::TABLE_DEPTH];
    int table_size;

    piecewise_linear_curve_lookup dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    task automatic send(pwl_pkg::in_item_t it);
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_transfer(it);
        items_sent++;
    endtask

    task automatic put_point(int idx, logic signed [31:0] x, logic signed [31:0] y);
        pwl_pkg::in_item_t it;
        it = '0;
        it.op = pwl_pkg::OP_WRITE;
        it.entry_index = idx[7:0];
        it.entry_x = x;
        it.entry_y = y;
        it.query_value = $urandom();
        send(it);
    endtask

    task automatic ask(logic signed [31:0] q);
        pwl_pkg::in_item_t it;
        it.op = pwl_pkg::OP_QUERY;
        it.entry_index = $urandom();
        it.entry_x = $urandom();
        it.entry_y = $urandom();
        it.query_value = q;
        send(it);
    endtask

    // Waits until every lookup has returned and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.lookups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic axis, int unsigned n);
        cfg_we <= 1'b1;
        cfg_index <= pwl_pkg::CFG_QUERY_AXIS;
        cfg_data <= {{(pwl_pkg::CFG_DATA_W-1){1'b0}}, axis};
        @(posedge clk);
        sb.set_register(pwl_pkg::CFG_QUERY_AXIS, {{(pwl_pkg::CFG_DATA_W-1){1'b0}}, axis});
        cfg_index <= pwl_pkg::CFG_POINT_COUNT;
        cfg_data <= n[pwl_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_register(pwl_pkg::CFG_POINT_COUNT, n[pwl_pkg::CFG_DATA_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    // Builds a key column in keys[], in non-decreasing order unless scrambled is set.
    task automatic make_keys(int n, bit scrambled);
        longint k;
        longint stride;
        stride = 64'd4294967295 / (n + 1);
        if ($urandom_range(0, 2) == 0)
            stride = $urandom_range(0, 64);
        else
            stride = $urandom_range(0, stride);
        k = -64'sd2147483648 + $urandom_range(0, 32'h7fffffff) % (stride * 4 + 1);
        for (int i = 0; i < n; i++)
        begin
            if (scrambled)
                keys[i] = $urandom();
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    k = k;
                else
                    k = k + $urandom_range(1, 32'hffff) % (stride + 1);
                if (k > 64'sd2147483647)
                    k = 64'sd2147483647;
                keys[i] = k[31:0];
            end
        end
    endtask

    task automatic pick_query(int n, bit axis);
        int i;
        longint lo;
        longint hi;
        longint q;
        case ($urandom_range(0, 9))
            0: ask($urandom());
            1: ask(keys[$urandom_range(0, n - 1)]);
            2: ask(keys[0] - $urandom_range(1, 3));
            3: ask(keys[n - 1] + $urandom_range(1, 3));
            default:
            begin
                i = $urandom_range(0, n - 1);
                lo = keys[(i == 0) ? 0 : i - 1];
                hi = keys[i];
                if (hi < lo)
                begin
                    q = lo;
                    lo = hi;
                    hi = q;
                end
                q = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
                ask(q[31:0]);
            end
        endcase
    endtask

    task automatic run_phase(int n, int unsigned count_reg, int n_ops, bit scrambled);
        bit axis;
        axis = $urandom_range(0, 1);
        make_keys(n, scrambled);
        for (int i = 0; i < n; i++)
        begin
            if (axis == pwl_pkg::AXIS_X)
                put_point(i, keys[i], $urandom());
            else
                put_point(i, $urandom(), keys[i]);
        end
        settle();
        configure(axis, count_reg);
        for (int j = 0; j < n_ops; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                put_point($urandom_range(0, 255), $urandom(), $urandom());
            else
                pick_query(n, axis);
        end
        settle();
        phases++;
    endtask

    initial
    begin
        int n;
        sb = new();
        items_sent = 0;
        phases = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: nothing can be found.
        ask(32'sd0);
        ask(32'h7fffffff);
        ask(32'h80000000);
        put_point(0, 32'h80000000, 32'h7fffffff);
        put_point(1, 32'h80000000, 32'h00000000);
        put_point(2, 32'h00000000, 32'h80000000);
        put_point(3, 32'h7fffffff, 32'h7fffffff);
        put_point(255, 32'hffffffff, 32'hffffffff);
        settle();
        configure(pwl_pkg::AXIS_X, 4);
        ask(32'h80000000);
        ask(32'hffffffff);
        ask(32'h00000000);
        ask(32'h00000001);
        ask(32'h7fffffff);
        settle();
        configure(pwl_pkg::AXIS_X, 3);
        ask(32'h00000001);
        ask(32'h80000000);
        ask(32'h00000000);
        settle();
        // Same points searched by y, which is not sorted there.
        configure(1'b1, 4);
        ask(32'h7fffffff);
        ask(32'h80000000);
        ask(32'h00000000);
        ask(32'h12345678);
        settle();

        while (items_sent < ITEM_TARGET)
        begin
            if (phases == 3)
                quiet = 1'b1;
            if (phases == 5)
                hold_cycles = 600;
            if (phases == 2)
                run_phase(pwl_pkg::TABLE_DEPTH, pwl_pkg::TABLE_DEPTH, 40, 1'b0);
            else if (phases == 6)
                run_phase(pwl_pkg::TABLE_DEPTH,
                          $urandom_range(pwl_pkg::TABLE_DEPTH + 1, 511), 40, 1'b0);
            else
            begin
                n = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 16);
                run_phase(n, n, $urandom_range(20, 40), $urandom_range(0, 9) == 0);
            end
            quiet = 1'b0;
        end

        if (sb.lookups_due.size() != 0)
            sb.mismatches++;
        $display("Covered %0d phases: %0d queries (%0d found), %0d table writes.",
                 phases, sb.queries, sb.hits, sb.writes);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
